FILE: rtl/ifa_pkg.sv
// Shared types, constants and helper functions of the integer-to-ASCII formatter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ifa_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int NUM_NIBBLES  = 16;
    localparam int DEC_WIDTH    = 32;
    localparam int DEC_DIGITS   = 10;
    localparam int BCD_WIDTH    = 4 * DEC_DIGITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int NIL_LENGTH   = 5;

    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] LOWER_OFS = 8'h57;
    localparam logic [7:0] UPPER_OFS = 8'h37;

    typedef enum logic [1:0] {
        OP_DEC  = 2'd0,
        OP_HEXL = 2'd1,
        OP_HEXU = 2'd2,
        OP_PTR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DEC,
        KIND_HEX,
        KIND_PTR,
        KIND_NIL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        upper;
        logic [63:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_NORM,
        ST_PREFIX,
        ST_DIGITS,
        ST_NIL
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ofs;
        ofs = upper ? UPPER_OFS : LOWER_OFS;
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        return ofs + {4'd0, d};
    endfunction

    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        return (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

    function automatic logic [7:0] nil_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6C;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/ifa_in_if.sv
// Input channel of the formatter: format selector and value with valid/ready.
// Depends on nothing.
interface ifa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

FILE: rtl/ifa_out_if.sv
// Output channel of the formatter: one character per item with valid/ready.
// Depends on nothing.
interface ifa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic [4:0] char_count;

    modport source (output valid, output character, output last, output char_count,
                    input ready);
    modport sink (input valid, input character, input last, input char_count,
                  output ready);
endinterface

FILE: rtl/ifa_front.sv
// Front part: accepts input items and classifies them into formatter commands.
// Depends on ifa_pkg and ifa_in_if.
module ifa_front
    import ifa_pkg::*;
(
    ifa_in_if.sink  i_in,
    output logic    o_cmd_valid,
    output t_cmd    o_cmd,
    input  logic    i_cmd_ready
);

    logic [63:0] masked;

    assign masked      = i_in.value & VALUE_MASK;
    assign o_cmd_valid = i_in.valid;
    assign i_in.ready  = i_cmd_ready;

    always_comb begin
        o_cmd.upper = 1'b0;
        o_cmd.value = masked;
        case (t_op'(i_in.operation))
            OP_HEXL: begin
                o_cmd.kind = KIND_HEX;
            end
            OP_HEXU: begin
                o_cmd.kind  = KIND_HEX;
                o_cmd.upper = 1'b1;
            end
            OP_PTR: begin
                o_cmd.kind = (masked == 64'd0) ? KIND_NIL : KIND_PTR;
            end
            default: begin
                o_cmd.kind  = KIND_DEC;
                o_cmd.value = {32'd0, i_in.value[DEC_WIDTH-1:0]};
            end
        endcase
    end

endmodule

FILE: rtl/ifa_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on ifa_pkg.
module ifa_queue
    import ifa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop,
    input  logic i_pop_ready
);

    t_cmd       r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/ifa_back.sv
// Back part: converts one command at a time to digits, or to "(nil)", and emits its characters in order.
// Decimal goes through a shift-and-add-3 converter; leading zeros are shifted out.
// Depends on ifa_pkg and ifa_out_if.
module ifa_back
    import ifa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_ready,
    ifa_out_if.source o_out
);

    t_state      r_state, n_state;
    logic [63:0] r_sh, n_sh;
    logic [31:0] r_bin, n_bin;
    logic [4:0]  r_cnt, n_cnt;
    logic [4:0]  r_left, n_left;
    logic [4:0]  r_total, n_total;
    logic        r_ptr, n_ptr;
    logic        r_upper, n_upper;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic [4:0]  r_count, n_count;
    logic        out_free;
    logic [BCD_WIDTH-1:0] adj;

    assign out_free        = !r_out_valid || o_out.ready;
    assign o_cmd_ready     = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;
    assign o_out.char_count = r_count;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i*4 +: 4] = bcd_adjust(r_sh[64-BCD_WIDTH + i*4 +: 4]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sh        = r_sh;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_total     = r_total;
        n_ptr       = r_ptr;
        n_upper     = r_upper;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        n_count     = r_count;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_upper = i_cmd.upper;
                    n_ptr   = (i_cmd.kind == KIND_PTR);
                    n_cnt   = 5'd0;
                    n_left  = 5'(NUM_NIBBLES);
                    n_sh    = i_cmd.value;
                    n_bin   = i_cmd.value[DEC_WIDTH-1:0];
                    case (i_cmd.kind)
                        KIND_DEC: begin
                            n_sh    = 64'd0;
                            n_state = ST_DABBLE;
                        end
                        KIND_NIL: n_state = ST_NIL;
                        default:  n_state = ST_NORM;
                    endcase
                end
            end
            ST_DABBLE: begin
                n_sh  = {adj[BCD_WIDTH-2:0], r_bin[DEC_WIDTH-1], {(64-BCD_WIDTH){1'b0}}};
                n_bin = {r_bin[DEC_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DEC_WIDTH - 1)) begin
                    n_left  = 5'(DEC_DIGITS);
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (r_sh[63:60] == 4'd0 && r_left > 5'd1) begin
                    n_sh   = {r_sh[59:0], 4'd0};
                    n_left = r_left - 5'd1;
                end else begin
                    n_total = r_left + (r_ptr ? 5'd2 : 5'd0);
                    n_cnt   = 5'd0;
                    n_state = r_ptr ? ST_PREFIX : ST_DIGITS;
                end
            end
            ST_PREFIX: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = r_cnt[0] ? CH_X : CH_ZERO;
                    n_last      = 1'b0;
                    n_count     = 5'd0;
                    n_cnt       = r_cnt + 5'd1;
                    if (r_cnt[0]) begin
                        n_state = ST_DIGITS;
                    end
                end
            end
            ST_DIGITS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_char(r_sh[63:60], r_upper);
                    n_last      = (r_left == 5'd1);
                    n_count     = (r_left == 5'd1) ? r_total : 5'd0;
                    n_sh        = {r_sh[59:0], 4'd0};
                    n_left      = r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_NIL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = nil_char(r_cnt[2:0]);
                    n_last      = (r_cnt == 5'(NIL_LENGTH - 1));
                    n_count     = (r_cnt == 5'(NIL_LENGTH - 1)) ? 5'(NIL_LENGTH) : 5'd0;
                    n_cnt       = r_cnt + 5'd1;
                    if (r_cnt == 5'(NIL_LENGTH - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh    <= n_sh;
        r_bin   <= n_bin;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_total <= n_total;
        r_ptr   <= n_ptr;
        r_upper <= n_upper;
        r_char  <= n_char;
        r_last  <= n_last;
        r_count <= n_count;
    end

endmodule

FILE: rtl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: front, command queue and back part.
// Depends on ifa_pkg, ifa_in_if, ifa_out_if, ifa_front, ifa_queue and ifa_back.
//
// Each input item prints one number as ASCII, one character per output item, most
// significant digit first, and the final character carries last and the total count.
// The front classifies an item in the cycle it is accepted and places it in a
// two-entry queue, so up to two further items are taken while one is being printed.
// The back part works on one item at a time. A decimal item first passes the
// bit-serial binary-to-BCD converter, then up to 9 leading zeros are shifted out,
// then one character per cycle is emitted. A hex or pointer item has up to 15 leading
// zero digits shifted out and then emits one character per cycle; "(nil)" is emitted
// the same way. The item is taken from the queue in the idle state, and the first
// digit is picked in the normalising state. A stalled output holds the back, so the
// rates above hold only while the output is free.
module integer_to_ascii_formatter
    import ifa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifa_in_if.sink    i_in,
    ifa_out_if.source o_out
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_ready;

    ifa_front u_front (
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    ifa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_valid),
        .i_push       (cmd),
        .o_push_ready (cmd_ready),
        .o_pop_valid  (q_valid),
        .o_pop        (q_cmd),
        .i_pop_ready  (q_ready)
    );

    ifa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/ifa_checker.sv
// Port-level assertions for the integer-to-ASCII formatter, bound to its top level.
// Depends on the top level's ports only.
module ifa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_character,
    input logic       i_last,
    input logic [4:0] i_char_count
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_char_count == 5'd0)
        else $error("A character before the last one carries a count.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_char_count >= 5'd1 && i_char_count <= 5'd18)
        else $error("The count on the last character is out of range.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_character >= 8'h28 && i_character <= 8'h78)
        else $error("An emitted character lies outside the printable set.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_character)
            && $stable(i_last) && $stable(i_char_count))
        else $error("A stalled output item changed.");

endmodule

bind integer_to_ascii_formatter ifa_checker u_ifa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_character  (o_out.character),
    .i_last       (o_out.last),
    .i_char_count (o_out.char_count)
);
